/* src/gpio_pkg.sv */
`timescale 1ns / 1ps

package gpio_pkg;

    localparam int NUM_PINS      = 54;
    localparam int DATA_W        = 32;
    localparam int WIDX_W        = 6;
    localparam int FSEL_W        = 3;
    localparam int PULL_W        = 2;
    localparam int FSEL_WORDS    = 6;
    localparam int PINS_PER_FSEL = 10;

    localparam logic [WIDX_W-1:0] WORD_SET_LO  = 6'd7;
    localparam logic [WIDX_W-1:0] WORD_SET_HI  = 6'd8;
    localparam logic [WIDX_W-1:0] WORD_CLR_LO  = 6'd10;
    localparam logic [WIDX_W-1:0] WORD_CLR_HI  = 6'd11;
    localparam logic [WIDX_W-1:0] WORD_LEV_LO  = 6'd13;
    localparam logic [WIDX_W-1:0] WORD_LEV_HI  = 6'd14;
    localparam logic [WIDX_W-1:0] WORD_PULL    = 6'd37;
    localparam logic [WIDX_W-1:0] WORD_PCLK_LO = 6'd38;
    localparam logic [WIDX_W-1:0] WORD_PCLK_HI = 6'd39;

    localparam logic [FSEL_W-1:0] CODE_OUTPUT = 3'd1;
    localparam logic [PULL_W-1:0] PULL_DOWN   = 2'd1;
    localparam logic [PULL_W-1:0] PULL_UP     = 2'd2;

    typedef enum logic {
        CMD_READ  = 1'b0,
        CMD_WRITE = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd                cmd;
        logic [WIDX_W-1:0]   word_index;
        logic [DATA_W-1:0]   write_data;
        logic [NUM_PINS-1:0] pad_levels;
    } t_req;

    typedef struct packed {
        logic [DATA_W-1:0]   read_data;
        logic [NUM_PINS-1:0] pad_out;
        logic [NUM_PINS-1:0] pad_output_enable;
        logic [NUM_PINS-1:0] pull_up_mask;
        logic [NUM_PINS-1:0] pull_down_mask;
    } t_rsp;

endpackage

/* src/gpio_in_stage.sv */
`timescale 1ns / 1ps

module gpio_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  gpio_pkg::t_req i_req,
    input  logic           i_adv,
    output logic           o_commit,
    output gpio_pkg::t_req o_req
);
    import gpio_pkg::*;

    logic r_valid;
    t_req r_req;

    assign o_commit = r_valid && i_adv;
    assign o_ready  = !r_valid || i_adv;
    assign o_req    = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_req <= i_req;
        end
    end

endmodule

/* src/gpio_core.sv */
`timescale 1ns / 1ps

module gpio_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_commit,
    input  gpio_pkg::t_req i_req,
    output gpio_pkg::t_rsp o_rsp
);
    import gpio_pkg::*;

    logic [FSEL_W-1:0]   r_fsel     [NUM_PINS];
    logic [FSEL_W-1:0]   n_fsel     [NUM_PINS];
    logic [PULL_W-1:0]   r_pin_pull [NUM_PINS];
    logic [PULL_W-1:0]   n_pin_pull [NUM_PINS];
    logic [NUM_PINS-1:0] r_latch;
    logic [NUM_PINS-1:0] n_latch;
    logic [PULL_W-1:0]   r_pull_mode;
    logic [PULL_W-1:0]   n_pull_mode;

    logic                is_write;
    logic [63:0]         lo64;
    logic [63:0]         hi64;
    logic [63:0]         lev64;
    logic [NUM_PINS-1:0] bank_lo;
    logic [NUM_PINS-1:0] bank_hi;
    logic [DATA_W-1:0]   rd;

    assign is_write = (i_req.cmd == CMD_WRITE);
    assign lo64     = {32'd0, i_req.write_data};
    assign hi64     = {i_req.write_data, 32'd0};
    assign lev64    = 64'(i_req.pad_levels);
    assign bank_lo  = lo64[NUM_PINS-1:0];
    assign bank_hi  = hi64[NUM_PINS-1:0];

    always_comb begin
        n_fsel      = r_fsel;
        n_pin_pull  = r_pin_pull;
        n_latch     = r_latch;
        n_pull_mode = r_pull_mode;
        rd          = '0;

        for (int p = 0; p < NUM_PINS; p++) begin
            if (p < FSEL_WORDS * PINS_PER_FSEL &&
                i_req.word_index == WIDX_W'(p / PINS_PER_FSEL)) begin
                if (is_write) begin
                    n_fsel[p] = i_req.write_data[(p % PINS_PER_FSEL) * FSEL_W +: FSEL_W];
                end else begin
                    rd[(p % PINS_PER_FSEL) * FSEL_W +: FSEL_W] = r_fsel[p];
                end
            end
        end

        if (is_write) begin
            unique case (i_req.word_index)
                WORD_SET_LO:  n_latch = r_latch | bank_lo;
                WORD_SET_HI:  n_latch = r_latch | bank_hi;
                WORD_CLR_LO:  n_latch = r_latch & ~bank_lo;
                WORD_CLR_HI:  n_latch = r_latch & ~bank_hi;
                WORD_PULL:    n_pull_mode = i_req.write_data[PULL_W-1:0];
                WORD_PCLK_LO: begin
                    for (int p = 0; p < NUM_PINS; p++) begin
                        if (bank_lo[p]) n_pin_pull[p] = r_pull_mode;
                    end
                end
                WORD_PCLK_HI: begin
                    for (int p = 0; p < NUM_PINS; p++) begin
                        if (bank_hi[p]) n_pin_pull[p] = r_pull_mode;
                    end
                end
                default: ;
            endcase
        end else begin
            unique case (i_req.word_index)
                WORD_LEV_LO: rd = lev64[31:0];
                WORD_LEV_HI: rd = lev64[63:32];
                WORD_PULL:   rd = {{(DATA_W-PULL_W){1'b0}}, r_pull_mode};
                default: ;
            endcase
        end
    end

    always_comb begin
        o_rsp.read_data = rd;
        o_rsp.pad_out   = n_latch;
        for (int p = 0; p < NUM_PINS; p++) begin
            o_rsp.pad_output_enable[p] = (n_fsel[p] == CODE_OUTPUT);
            o_rsp.pull_up_mask[p]      = (n_pin_pull[p] == PULL_UP);
            o_rsp.pull_down_mask[p]    = (n_pin_pull[p] == PULL_DOWN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latch     <= '0;
            r_pull_mode <= '0;
            for (int p = 0; p < NUM_PINS; p++) begin
                r_fsel[p]     <= '0;
                r_pin_pull[p] <= '0;
            end
        end else if (i_commit) begin
            r_latch     <= n_latch;
            r_pull_mode <= n_pull_mode;
            r_fsel      <= n_fsel;
            r_pin_pull  <= n_pin_pull;
        end
    end

    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_commit |=> $stable(r_latch) && $stable(r_pull_mode))
        else $error("state moved without a request");

    a_read_no_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_commit && !is_write |=> $stable(r_latch) && $stable(r_pull_mode))
        else $error("read changed state");

    a_set_lo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_commit && is_write && i_req.word_index == WORD_SET_LO
        |=> (r_latch & $past(bank_lo)) == $past(bank_lo))
        else $error("set word did not set latch bits");

    a_clr_lo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_commit && is_write && i_req.word_index == WORD_CLR_LO
        |=> (r_latch & $past(bank_lo)) == '0)
        else $error("clear word did not clear latch bits");

    a_write_rd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_write |-> rd == '0)
        else $error("write returned read data");

endmodule

/* src/gpio_out_stage.sv */
`timescale 1ns / 1ps

module gpio_out_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  gpio_pkg::t_rsp i_rsp,
    output logic           o_free,
    output logic           o_valid,
    input  logic           i_ready,
    output gpio_pkg::t_rsp o_rsp
);
    import gpio_pkg::*;

    logic r_valid;
    t_rsp r_rsp;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rsp <= i_rsp;
        end
    end

endmodule

/* src/gpio_register_block_unit.sv */
`timescale 1ns / 1ps

// channel  | handshake                  | payload
// ---------+----------------------------+------------------------------------------
// request  | i_in_valid / o_in_ready    | i_cmd, i_word_index, i_write_data,
//          |                            | i_pad_levels
// result   | o_out_valid / i_out_ready  | o_read_data, o_pad_out, o_pad_output_enable,
//          |                            | o_pull_up_mask, o_pull_down_mask
//
// One request per cycle while results are taken; each accepted request passes the
// input register, then the result register, with decode and update between them.
// Synchronous active-low reset clears all pin state to input, latch 0, pull off.
// A stalled result holds in the result register while the next request
// waits in the input register; o_in_ready drops only when both are full.

module gpio_register_block_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_cmd,
    input  logic [gpio_pkg::WIDX_W-1:0]    i_word_index,
    input  logic [gpio_pkg::DATA_W-1:0]    i_write_data,
    input  logic [gpio_pkg::NUM_PINS-1:0]  i_pad_levels,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [gpio_pkg::DATA_W-1:0]    o_read_data,
    output logic [gpio_pkg::NUM_PINS-1:0]  o_pad_out,
    output logic [gpio_pkg::NUM_PINS-1:0]  o_pad_output_enable,
    output logic [gpio_pkg::NUM_PINS-1:0]  o_pull_up_mask,
    output logic [gpio_pkg::NUM_PINS-1:0]  o_pull_down_mask
);
    import gpio_pkg::*;

    t_req in_req;
    t_req core_req;
    t_rsp core_rsp;
    t_rsp out_rsp;
    logic commit;
    logic out_free;

    assign in_req.cmd        = t_cmd'(i_cmd);
    assign in_req.word_index = i_word_index;
    assign in_req.write_data = i_write_data;
    assign in_req.pad_levels = i_pad_levels;

    gpio_in_stage u_in (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_req    (in_req),
        .i_adv    (out_free),
        .o_commit (commit),
        .o_req    (core_req)
    );

    gpio_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_commit (commit),
        .i_req    (core_req),
        .o_rsp    (core_rsp)
    );

    gpio_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (commit),
        .i_rsp   (core_rsp),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_rsp   (out_rsp)
    );

    assign o_read_data         = out_rsp.read_data;
    assign o_pad_out           = out_rsp.pad_out;
    assign o_pad_output_enable = out_rsp.pad_output_enable;
    assign o_pull_up_mask      = out_rsp.pull_up_mask;
    assign o_pull_down_mask    = out_rsp.pull_down_mask;

endmodule
